FILE: hdl/bwdg_pkg.sv
`default_nettype none

package bwdg_pkg;

	// Phase and table resolution
	localparam int PHASE_BITS     = 16;
	localparam int COS_TABLE_BITS = 10;

	// Phase sum carries one extra fraction bit
	localparam int SUM_W  = PHASE_BITS + 1;
	localparam int TERM_W = 48;

	// Field widths
	localparam int NOW_W     = 32;
	localparam int PERIOD_W  = 16;
	localparam int STEP_W    = 16;
	localparam int LED_W     = 8;
	localparam int PULSE_W   = 12;
	localparam int DRIVE_W   = 12;
	localparam int LEVEL_W   = 16;
	localparam int HC_W      = 6;
	localparam int COL_PROD_W = HC_W + STEP_W;
	localparam int ROW_PROD_W = 4 + STEP_W;

	// Time-to-phase divider: remainder of now_ms, then SUM_W fraction bits
	localparam int DIV_STEPS           = NOW_W + SUM_W;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES          =
		(DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

	// Cycles from an accepted request to its result strobe
	localparam int LATENCY = DIV_STAGES + 7;

	// Term alignment to the phase sum
	localparam int SIDE_SHL = (PHASE_BITS >= 15) ? PHASE_BITS - 15 : 0;
	localparam int SIDE_SHR = (PHASE_BITS >= 15) ? 0 : 15 - PHASE_BITS;
	localparam int COL_SHL  = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
	localparam int COL_SHR  = (PHASE_BITS >= 16) ? 0 : 16 - PHASE_BITS;
	localparam int IDX_SHL  = (COS_TABLE_BITS > PHASE_BITS) ? COS_TABLE_BITS - PHASE_BITS : 0;
	localparam int IDX_SHR  = (PHASE_BITS >= COS_TABLE_BITS) ? PHASE_BITS - COS_TABLE_BITS : 0;

	// Wave table: the half turn 0..N/2 is split into banks of at most 256 entries,
	// entry N/2 stands apart
	localparam int WAVE_SIZE  = 1 << COS_TABLE_BITS;
	localparam int WAVE_HALF  = WAVE_SIZE / 2;
	localparam int BANK_BITS  = (COS_TABLE_BITS - 1 > 8) ? 8 : COS_TABLE_BITS - 1;
	localparam int BANK_SIZE  = 1 << BANK_BITS;
	localparam int NUM_BANKS  = WAVE_HALF / BANK_SIZE;
	localparam int BANK_SEL_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_OFFSET = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_MIN     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_MAX     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX   = 4'd7;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd5200;
	localparam logic [STEP_W-1:0]   COL_STEP_RESET  = 16'd3338;
	localparam logic [STEP_W-1:0]   ROW_STEP_RESET  = 16'd4798;
	localparam logic [STEP_W-1:0]   SIDE_OFS_RESET  = 16'd11995;
	localparam logic [LED_W-1:0]    LED_MIN_RESET   = 8'd2;
	localparam logic [LED_W-1:0]    LED_MAX_RESET   = 8'd20;
	localparam logic [PULSE_W-1:0]  PULSE_MIN_RESET = 12'd1540;
	localparam logic [PULSE_W-1:0]  PULSE_MAX_RESET = 12'd1740;

	// Field codes
	localparam logic OP_LED     = 1'b0;
	localparam logic OP_SERVO   = 1'b1;
	localparam logic SURF_FRONT = 1'b0;
	localparam logic SURF_SIDE  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [NOW_W-1:0]  now_ms;
		logic              surface;
		logic [3:0]        row;
		logic [3:0]        col;
		logic [2:0]        col_span;
	} bwdg_req_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive_value;
		logic [LEVEL_W-1:0] wave_level;
	} bwdg_result_t;

	typedef logic [BANK_SIZE-1:0][LEVEL_W-1:0] wave_bank_t;

	// sin^2(pi*k2/N) in Q0.16 from an integer sine series in Q2.30
	function automatic logic [LEVEL_W-1:0] wave_entry(input int unsigned k2);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] w;
		logic [63:0] q;
		x  = (PI_Q30 * 64'(k2)) >> COS_TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = ONE_Q30 - x2 / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		t  = (x * t) >> 30;
		if (t > ONE_Q30) begin
			t = ONE_Q30;
		end
		w = (t * t) >> 30;
		q = (w + 64'd8192) >> 14;
		return (q > 64'd65535) ? 16'hFFFF : q[LEVEL_W-1:0];
	endfunction

	function automatic wave_bank_t build_bank(input int unsigned bank);
		wave_bank_t b;
		for (int unsigned i = 0; i < BANK_SIZE; i++) begin
			b[i] = wave_entry(bank * BANK_SIZE + i);
		end
		return b;
	endfunction

	localparam logic [LEVEL_W-1:0] WAVE_TOP = wave_entry(WAVE_HALF);

endpackage

`default_nettype wire

FILE: hdl/breathing_wave_drive_generator.sv
`default_nettype none

// Breathing wave drive generator.
//
// Request channel: a request (one grid unit: LED or servo, time, surface, row,
// column, column span) is taken at a rising edge with start high and busy low.
// busy stays low: the pipeline takes one request every cycle without pause.
// Result channel: done marks the single cycle in which result holds the drive
// value and the gamma-corrected wave level. The receiver takes it at the edge
// that ends that cycle; it cannot stall, so no result is ever held back.
// Throughput: one request per cycle. The pipeline runs from the accepting edge
// to the edge that takes the result through one stage of phase offsets, the
// time-to-phase divider (49 restoring steps, four per stage in 13 stages), then
// the table index, bank read, bank select and square, gamma round, blend multiply
// and the blend round into the output register.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// indexes beyond the register list are dropped. Write only while no request
// is in flight; each stage reads the registers directly.
// Reset: arst_n clears all valid bits and loads the register defaults; results
// of requests in flight at reset are dropped. The wave table is constant logic.
module breathing_wave_drive_generator import bwdg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire bwdg_req_t             request,
	output logic                       done,
	output bwdg_result_t               result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------------------------------------------------------- config
	logic [PERIOD_W-1:0] period_q;
	logic [STEP_W-1:0]   col_step_q;
	logic [STEP_W-1:0]   row_step_q;
	logic [STEP_W-1:0]   side_ofs_q;
	logic [LED_W-1:0]    led_min_q;
	logic [LED_W-1:0]    led_max_q;
	logic [PULSE_W-1:0]  pulse_min_q;
	logic [PULSE_W-1:0]  pulse_max_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			col_step_q  <= COL_STEP_RESET;
			row_step_q  <= ROW_STEP_RESET;
			side_ofs_q  <= SIDE_OFS_RESET;
			led_min_q   <= LED_MIN_RESET;
			led_max_q   <= LED_MAX_RESET;
			pulse_min_q <= PULSE_MIN_RESET;
			pulse_max_q <= PULSE_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PERIOD_MS:   period_q    <= cfg_data;
				CFG_COL_STEP:    col_step_q  <= cfg_data;
				CFG_ROW_STEP:    row_step_q  <= cfg_data;
				CFG_SIDE_OFFSET: side_ofs_q  <= cfg_data;
				CFG_LED_MIN:     led_min_q   <= cfg_data[LED_W-1:0];
				CFG_LED_MAX:     led_max_q   <= cfg_data[LED_W-1:0];
				CFG_PULSE_MIN:   pulse_min_q <= cfg_data[PULSE_W-1:0];
				CFG_PULSE_MAX:   pulse_max_q <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero period behaves as one millisecond
	logic [PERIOD_W-1:0] period_eff;
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// ------------------------------------------------ stage 1: phase offsets
	logic                  vld_s1;
	logic [NOW_W-1:0]      now_s1;
	logic                  servo_s1;
	logic [SUM_W-1:0]      side_s1;
	logic [SUM_W-1:0]      col_s1;
	logic [SUM_W-1:0]      row_s1;

	logic [2:0]            span_eff;
	logic [HC_W-1:0]       half_col;
	logic [COL_PROD_W-1:0] col_prod;
	logic [ROW_PROD_W-1:0] row_prod;
	logic                  is_servo;

	assign is_servo = (request.operation == OP_SERVO);
	assign span_eff = (request.col_span == 3'd0) ? 3'd1 : request.col_span;

	// Column centre in half-columns; servos sit on the column itself
	always_comb begin
		half_col = {1'b0, request.col, 1'b0};
		if (!is_servo) begin
			half_col = half_col + HC_W'(span_eff) - HC_W'(1);
		end
	end

	assign col_prod = COL_PROD_W'(half_col) * COL_PROD_W'(col_step_q);
	assign row_prod = ROW_PROD_W'(request.row) * ROW_PROD_W'(row_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		now_s1   <= request.now_ms;
		servo_s1 <= is_servo;
		side_s1  <= (request.surface == SURF_SIDE) ?
			SUM_W'((TERM_W'(side_ofs_q) << SIDE_SHL) >> SIDE_SHR) : '0;
		col_s1   <= SUM_W'((TERM_W'(col_prod) << COL_SHL) >> COL_SHR);
		row_s1   <= is_servo ? SUM_W'((TERM_W'(row_prod) << SIDE_SHL) >> SIDE_SHR) : '0;
	end

	// ------------------------------------- stage 2: restoring divider chain
	// Divide now_ms * 2^SUM_W by the period; the low SUM_W quotient bits are
	// the base phase ((now mod period) << SUM_W) / period.
	typedef struct packed {
		logic [DIV_STEPS-1:0] num;
		logic [PERIOD_W-1:0]  rem;
		logic [SUM_W-1:0]     quo;
		logic [SUM_W-1:0]     ofs;
		logic                 servo;
	} div_pay_t;

	logic     div_vld_s2 [DIV_STAGES];
	div_pay_t div_s2     [DIV_STAGES];
	div_pay_t div_in     [DIV_STAGES];
	div_pay_t div_nxt    [DIV_STAGES];

	always_comb begin
		div_in[0].num   = {now_s1, SUM_W'(0)};
		div_in[0].rem   = '0;
		div_in[0].quo   = '0;
		div_in[0].ofs   = side_s1 + col_s1 + row_s1;
		div_in[0].servo = servo_s1;
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		if (j > 0) begin : g_link
			assign div_in[j] = div_s2[j-1];
		end

		always_comb begin : p_steps
			div_pay_t          d;
			logic [PERIOD_W:0] trial;
			d = div_in[j];
			for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
				if (j * DIV_STEPS_PER_STAGE + i < DIV_STEPS) begin
					trial = {d.rem, d.num[DIV_STEPS-1]};
					d.num = d.num << 1;
					if (trial >= {1'b0, period_eff}) begin
						trial = trial - {1'b0, period_eff};
						d.quo = {d.quo[SUM_W-2:0], 1'b1};
					end else begin
						d.quo = {d.quo[SUM_W-2:0], 1'b0};
					end
					d.rem = trial[PERIOD_W-1:0];
				end
			end
			div_nxt[j] = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s2[j] <= 1'b0;
			end else begin
				div_vld_s2[j] <= (j == 0) ? vld_s1 : div_vld_s2[(j > 0) ? j - 1 : 0];
			end
		end

		always_ff @(posedge clk) begin
			div_s2[j] <= div_nxt[j];
		end
	end

	// ------------------------------------------ stage 3: phase and table index
	logic                      vld_s3;
	logic                      servo_s3;
	logic                      top_s3;
	logic [BANK_SEL_W-1:0]     sel_s3;
	logic [BANK_BITS-1:0]      off_s3;

	logic [SUM_W-1:0]          phase_sum;
	logic [PHASE_BITS-1:0]     phase;
	logic [COS_TABLE_BITS-1:0] tab_k;
	logic [COS_TABLE_BITS-1:0] tab_k2;
	logic                      tab_top;

	assign phase_sum = div_s2[DIV_STAGES-1].quo + div_s2[DIV_STAGES-1].ofs;
	assign phase     = phase_sum[SUM_W-1:1];
	assign tab_k     = COS_TABLE_BITS'((TERM_W'(phase) << IDX_SHL) >> IDX_SHR);
	// Fold the second half turn: N - k modulo N
	assign tab_k2    = (tab_k <= COS_TABLE_BITS'(WAVE_HALF)) ? tab_k : -tab_k;
	assign tab_top   = (tab_k2 == COS_TABLE_BITS'(WAVE_HALF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= div_vld_s2[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		servo_s3 <= div_s2[DIV_STAGES-1].servo;
		top_s3   <= tab_top;
		sel_s3   <= tab_top ? '0 : BANK_SEL_W'(tab_k2 >> BANK_BITS);
		off_s3   <= tab_k2[BANK_BITS-1:0];
	end

	// ----------------------------------------------- stage 4: read all banks
	logic               vld_s4;
	logic               servo_s4;
	logic               top_s4;
	logic [BANK_SEL_W-1:0] sel_s4;
	logic [LEVEL_W-1:0] bank_s4 [NUM_BANKS];

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam wave_bank_t BankRom = build_bank(b);
		always_ff @(posedge clk) begin
			bank_s4[b] <= BankRom[off_s3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		servo_s4 <= servo_s3;
		top_s4   <= top_s3;
		sel_s4   <= sel_s3;
	end

	// ---------------------------------------- stage 5: bank select and square
	logic                 vld_s5;
	logic                 servo_s5;
	logic [2*LEVEL_W-1:0] sq_s5;
	logic [LEVEL_W-1:0]   wave_w;

	assign wave_w = top_s4 ? WAVE_TOP : bank_s4[sel_s4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		servo_s5 <= servo_s4;
		sq_s5    <= (2*LEVEL_W)'(wave_w) * (2*LEVEL_W)'(wave_w);
	end

	// ---------------------------------- stage 6: gamma round, pick the limits
	logic               vld_s6;
	logic [LEVEL_W-1:0] gam_s6;
	logic [PULSE_W-1:0] lo_s6;
	logic [PULSE_W-1:0] hi_s6;
	logic [2*LEVEL_W-1:0] sq_round;

	// Cannot overflow: 65535^2 + 2^15 stays below 2^32
	assign sq_round = sq_s5 + (2*LEVEL_W)'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		gam_s6 <= sq_round[2*LEVEL_W-1:LEVEL_W];
		lo_s6  <= servo_s5 ? pulse_min_q : PULSE_W'(led_min_q);
		hi_s6  <= servo_s5 ? pulse_max_q : PULSE_W'(led_max_q);
	end

	// ------------------------------------------------ stage 7: blend products
	localparam int PROD_W  = PULSE_W + LEVEL_W + 1;
	localparam int BLEND_W = PROD_W + 1;

	logic               vld_s7;
	logic [LEVEL_W-1:0] gam_s7;
	logic [PROD_W-1:0]  plo_s7;
	logic [PROD_W-1:0]  phi_s7;
	logic [LEVEL_W:0]   gam_inv;

	assign gam_inv = {1'b1, LEVEL_W'(0)} - {1'b0, gam_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		gam_s7 <= gam_s6;
		plo_s7 <= PROD_W'(lo_s6) * PROD_W'(gam_inv);
		phi_s7 <= PROD_W'(hi_s6) * PROD_W'(gam_s6);
	end

	// ------------------------------------- stage 8: round, clamp, drive out
	logic                 done_s8;
	bwdg_result_t         out_s8;
	logic [BLEND_W-1:0]   blend_sum;
	logic [BLEND_W-LEVEL_W-1:0] blend_val;
	logic [DRIVE_W-1:0]   drive;

	assign blend_sum = BLEND_W'(plo_s7) + BLEND_W'(phi_s7) + BLEND_W'(32768);
	assign blend_val = blend_sum[BLEND_W-1:LEVEL_W];
	assign drive     = (blend_val > (BLEND_W-LEVEL_W)'(4095)) ? DRIVE_W'(4095)
		: blend_val[DRIVE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s8 <= 1'b0;
		end else begin
			done_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		out_s8.drive_value <= drive;
		out_s8.wave_level  <= gam_s7;
	end

	assign done   = done_s8;
	assign result = out_s8;

endmodule

`default_nettype wire

FILE: hdl/bwdg_checker.sv
`default_nettype none

module bwdg_assertions import bwdg_pkg::*; (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         start,
	input wire logic         busy,
	input wire bwdg_req_t    request,
	input wire logic         done,
	input wire bwdg_result_t result
);

	// Each accepted request gives its result after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing after accepted request");

	// No strobe without an accepted request at the matching earlier edge
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without matching request");

	// LED drive blends 8-bit levels and must stay within 8 bits
	a_led_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(request.operation, LATENCY) == OP_LED))
		|-> (result.drive_value[DRIVE_W-1:LED_W] == '0))
		else $error("LED drive value exceeds 8 bits");

	// Zero phase (time zero, front, first column, single span) gives zero level
	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (request.operation == OP_LED)
			&& (request.surface == SURF_FRONT) && (request.col == 4'd0)
			&& (request.now_ms == '0)
			&& ((request.col_span == 3'd1) || (request.col_span == 3'd0)), LATENCY))
		|-> (result.wave_level == '0))
		else $error("wave level not zero at zero phase");

endmodule

bind breathing_wave_drive_generator bwdg_assertions u_bwdg_assertions (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

`default_nettype wire

FILE: dv/bwdg_checker.sv
`default_nettype none

module bwdg_checker import bwdg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire bwdg_req_t             request,
	input  wire logic                  done,
	input  wire bwdg_result_t          result,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned                fail_count,
	output int unsigned                outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LUT_SIZE = 1 << COS_TABLE_BITS;
	localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
	localparam longint unsigned UNIT_Q30      = 64'd1 << 30;

	// Shadow copy of the register file
	logic [PERIOD_W-1:0] rate_period;
	logic [STEP_W-1:0]   col_step;
	logic [STEP_W-1:0]   row_step;
	logic [STEP_W-1:0]   side_ofs;
	logic [LED_W-1:0]    led_lo;
	logic [LED_W-1:0]    led_hi;
	logic [PULSE_W-1:0]  pulse_lo;
	logic [PULSE_W-1:0]  pulse_hi;

	logic [LEVEL_W-1:0] sin_sq_lut [0:LUT_SIZE-1];
	bwdg_result_t       pending_drive [$];
	int unsigned        fails = 0;

	// sin^2 over one turn, Q0.16, from a Horner sine series in Q2.30
	initial begin
		longint unsigned k2, x, x2, t, w, q;
		for (int k = 0; k < LUT_SIZE; k++) begin
			k2 = (k <= LUT_SIZE / 2) ? 64'(k) : 64'(LUT_SIZE - k);
			x  = (HALF_TURN_Q30 * k2) >> COS_TABLE_BITS;
			x2 = (x * x) >> 30;
			t  = UNIT_Q30 - x2 / 110;
			t  = UNIT_Q30 - ((x2 * t) >> 30) / 72;
			t  = UNIT_Q30 - ((x2 * t) >> 30) / 42;
			t  = UNIT_Q30 - ((x2 * t) >> 30) / 20;
			t  = UNIT_Q30 - ((x2 * t) >> 30) / 6;
			t  = (x * t) >> 30;
			if (t > UNIT_Q30) begin
				t = UNIT_Q30;
			end
			w = (t * t) >> 30;
			q = (w + 64'd8192) >> 14;
			sin_sq_lut[k] = (q > 64'd65535) ? 16'hFFFF : q[LEVEL_W-1:0];
		end
	end

	function automatic longint unsigned align(longint unsigned v, int sh);
		return (sh >= 0) ? (v << sh) : (v >> -sh);
	endfunction

	function automatic bwdg_result_t drive_for(bwdg_req_t r);
		longint unsigned period, span, hc, sum, ph, idx, w, g, lo, hi, v;
		bwdg_result_t res;
		period = (rate_period == '0) ? 64'd1 : 64'(rate_period);
		span   = (r.col_span == '0) ? 64'd1 : 64'(r.col_span);
		sum    = ((longint'(r.now_ms) % period) << SUM_W) / period;
		if (r.surface == SURF_SIDE) begin
			sum += align(64'(side_ofs), PHASE_BITS - 15);
		end
		hc = (r.operation == OP_SERVO) ? 64'd2 * 64'(r.col) : 64'd2 * 64'(r.col) + span - 1;
		sum += align(hc * 64'(col_step), PHASE_BITS - 16);
		if (r.operation == OP_SERVO) begin
			sum += align(64'(r.row) * 64'(row_step), PHASE_BITS - 15);
		end
		sum &= (64'd1 << SUM_W) - 1;
		ph  = sum >> 1;
		idx = align(ph, COS_TABLE_BITS - PHASE_BITS) & (LUT_SIZE - 1);
		w   = 64'(sin_sq_lut[idx[COS_TABLE_BITS-1:0]]);
		g   = (w * w + 64'd32768) >> 16;
		if (g > 64'd65535) begin
			g = 64'd65535;
		end
		lo = (r.operation == OP_SERVO) ? 64'(pulse_lo) : 64'(led_lo);
		hi = (r.operation == OP_SERVO) ? 64'(pulse_hi) : 64'(led_hi);
		v  = (lo * (64'd65536 - g) + hi * g + 64'd32768) >> 16;
		res.drive_value = (v > 64'd4095) ? 12'hFFF : v[DRIVE_W-1:0];
		res.wave_level  = g[LEVEL_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bwdg_result_t want;
		if (!arst_n) begin
			rate_period = PERIOD_RESET;
			col_step    = COL_STEP_RESET;
			row_step    = ROW_STEP_RESET;
			side_ofs    = SIDE_OFS_RESET;
			led_lo      = LED_MIN_RESET;
			led_hi      = LED_MAX_RESET;
			pulse_lo    = PULSE_MIN_RESET;
			pulse_hi    = PULSE_MAX_RESET;
			pending_drive.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PERIOD_MS:   rate_period = cfg_data;
					CFG_COL_STEP:    col_step    = cfg_data;
					CFG_ROW_STEP:    row_step    = cfg_data;
					CFG_SIDE_OFFSET: side_ofs    = cfg_data;
					CFG_LED_MIN:     led_lo      = cfg_data[LED_W-1:0];
					CFG_LED_MAX:     led_hi      = cfg_data[LED_W-1:0];
					CFG_PULSE_MIN:   pulse_lo    = cfg_data[PULSE_W-1:0];
					CFG_PULSE_MAX:   pulse_hi    = cfg_data[PULSE_W-1:0];
					default: ;
				endcase
			end
			// retire before predicting so a same-edge request never meets itself
			if (done) begin
				if (pending_drive.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("%t: result with nothing pending: drive=%0d level=%0d",
							$time, result.drive_value, result.wave_level);
					end
				end else begin
					want = pending_drive.pop_front();
					if (result.drive_value !== want.drive_value ||
							result.wave_level !== want.wave_level) begin
						fails++;
						if (fails <= 10) begin
							$display("%t: drive exp %0d got %0d, level exp %0d got %0d",
								$time, want.drive_value, result.drive_value,
								want.wave_level, result.wave_level);
						end
					end
				end
			end
			if (start && !busy) begin
				pending_drive.push_back(drive_for(request));
			end
		end
		outstanding <= pending_drive.size();
		fail_count  <= fails;
	end

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bwdg_pkg::*;

	// Cycles with no request, result or register write before giving up
	localparam int STALL_LIMIT       = 5000;
	localparam int ITEMS_PER_CHUNK   = 25;
	localparam int RANDOM_SETTINGS   = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_PULSE_MAX + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	bwdg_req_t             request   = '0;
	logic                  done;
	bwdg_result_t          result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned stall_cycles = 0;
	int unsigned idle_pct     = 0;
	int unsigned cur_period   = 32'(PERIOD_RESET);

	breathing_wave_drive_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bwdg_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5ns clk = ~clk;
	end

	// Watchdog: any handshake counts as progress, otherwise advance the stall count
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic bwdg_req_t mk(logic op, logic [NOW_W-1:0] now, logic surf,
			logic [3:0] row, logic [3:0] col, logic [2:0] span);
		bwdg_req_t r;
		r.operation = op;
		r.now_ms    = now;
		r.surface   = surf;
		r.row       = row;
		r.col       = col;
		r.col_span  = span;
		return r;
	endfunction

	// Random request: mostly legal spans, a share of odd ones; times spread over
	// the full 32-bit range, the first periods and the wrap at the top
	function automatic bwdg_req_t rand_item(int unsigned period);
		bwdg_req_t r;
		r.operation = 1'($urandom_range(1));
		case ($urandom_range(3))
			0, 1: r.now_ms = $urandom;
			2:    r.now_ms = $urandom_range(3 * period + 2);
			default: r.now_ms = 32'hFFFF_FFFF - $urandom_range(3 * period + 2);
		endcase
		r.surface = 1'($urandom_range(1));
		r.row     = 4'($urandom);
		r.col     = 4'($urandom);
		if ($urandom_range(4) == 0) begin
			r.col_span = 3'($urandom);
		end else if (r.operation == OP_SERVO) begin
			r.col_span = 3'd1;
		end else begin
			r.col_span = 3'($urandom_range(1, 4));
		end
		return r;
	endfunction

	// Present one request and hold it until taken; then draw the sender gap
	task automatic send(input bwdg_req_t r);
		int unsigned gap;
		gap = 0;
		request <= r;
		start   <= 1'b1;
		do @(posedge clk); while (busy);
		while ($urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start, wait for every pending result, then let the pipe settle
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Hold one register write until the channel takes it; caller drops valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Reprogram the whole register file with the block idle; also hit an
	// unused index, which must leave every register untouched
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] period,
			input logic [CFG_DATA_W-1:0] col_step, input logic [CFG_DATA_W-1:0] row_step,
			input logic [CFG_DATA_W-1:0] side_ofs, input logic [CFG_DATA_W-1:0] led_lo,
			input logic [CFG_DATA_W-1:0] led_hi, input logic [CFG_DATA_W-1:0] pulse_lo,
			input logic [CFG_DATA_W-1:0] pulse_hi);
		drain();
		write_reg(CFG_PERIOD_MS, period);
		write_reg(CFG_COL_STEP, col_step);
		write_reg(CFG_ROW_STEP, row_step);
		write_reg(CFG_SIDE_OFFSET, side_ofs);
		write_reg(CFG_LED_MIN, led_lo);
		write_reg(CFG_LED_MAX, led_hi);
		write_reg(CFG_PULSE_MIN, pulse_lo);
		write_reg(CFG_PULSE_MAX, pulse_hi);
		write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
			CFG_DATA_W'($urandom));
		cfg_valid  <= 1'b0;
		cur_period = 32'(period);
	endtask

	initial begin
		int unsigned idle_plan [3];
		idle_plan = '{0, 70, 7};

		// Hold reset low, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with the reset register values, back to back.
		// Phase zero and the half period give the bottom and the top of the wave.
		send(mk(OP_LED,   32'd0,    SURF_FRONT, 4'd0,  4'd0,  3'd1));
		send(mk(OP_LED,   32'd2600, SURF_FRONT, 4'd0,  4'd0,  3'd1));
		send(mk(OP_LED,   '1,       SURF_SIDE,  4'd15, 4'd15, 3'd4));
		send(mk(OP_SERVO, 32'd0,    SURF_FRONT, 4'd0,  4'd0,  3'd1));
		send(mk(OP_SERVO, 32'd2600, SURF_FRONT, 4'd0,  4'd0,  3'd1));
		// servo ignores the span, LED ignores the row
		send(mk(OP_SERVO, '1,       SURF_SIDE,  4'd15, 4'd15, 3'd7));
		send(mk(OP_LED,   32'd1300, SURF_FRONT, 4'd9,  4'd3,  3'd0));
		// spans beyond four are used as given
		send(mk(OP_LED,   32'd1300, SURF_FRONT, 4'd0,  4'd3,  3'd5));
		send(mk(OP_LED,   32'd1300, SURF_FRONT, 4'd0,  4'd3,  3'd6));
		send(mk(OP_LED,   32'd1300, SURF_FRONT, 4'd0,  4'd3,  3'd7));
		send(mk(OP_SERVO, 32'd5199, SURF_SIDE,  4'd15, 4'd0,  3'd0));
		send(mk(OP_LED,   32'd5200, SURF_SIDE,  4'd0,  4'd15, 3'd2));

		// Zero period acts as one; maximum steps; limits inverted so drive falls
		apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'd255, 16'd0, 16'd4095, 16'd0);
		send(mk(OP_LED,   '1,        SURF_SIDE,  4'd15, 4'd15, 3'd4));
		send(mk(OP_SERVO, 32'd12345, SURF_FRONT, 4'd15, 4'd15, 3'd1));
		send(mk(OP_LED,   32'd0,     SURF_FRONT, 4'd0,  4'd0,  3'd1));
		send(mk(OP_SERVO, '1,        SURF_SIDE,  4'd7,  4'd8,  3'd1));

		// Period of one, no steps, full drive ranges
		apply_setting(16'd1, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd255, 16'd0, 16'd4095);
		send(mk(OP_LED,   32'd7,   SURF_SIDE,  4'd3,  4'd15, 3'd4));
		send(mk(OP_SERVO, 32'd999, SURF_FRONT, 4'd15, 4'd15, 3'd1));
		send(mk(OP_LED,   '1,      SURF_FRONT, 4'd0,  4'd0,  3'd1));

		// Random part: each setting runs three chunks, one per idle pattern
		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			case (s)
				0: apply_setting(PERIOD_RESET, COL_STEP_RESET, ROW_STEP_RESET,
					SIDE_OFS_RESET, CFG_DATA_W'(LED_MIN_RESET), CFG_DATA_W'(LED_MAX_RESET),
					CFG_DATA_W'(PULSE_MIN_RESET), CFG_DATA_W'(PULSE_MAX_RESET));
				1: apply_setting(16'hFFFF, 16'd0, 16'd0, 16'd0,
					16'd0, 16'd255, 16'd0, 16'd4095);
				2: apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'd255, 16'd0, 16'd4095, 16'd0);
				// random settings; narrow registers get random upper bits to drop
				3: apply_setting(CFG_DATA_W'($urandom_range(1, 200)),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom));
				default: apply_setting(CFG_DATA_W'($urandom_range(1, 20000)),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom));
			endcase
			for (int c = 0; c < 3; c++) begin
				idle_pct = idle_plan[c];
				repeat (ITEMS_PER_CHUNK) send(rand_item(cur_period));
			end
			idle_pct = 0;
		end

		// Wait out the last results, then give the verdict
		drain();
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/bwdg_pkg.sv
hdl/breathing_wave_drive_generator.sv
hdl/bwdg_checker.sv
dv/bwdg_checker.sv
dv/tb.sv
